// ----- rtl/itoa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the integer-to-ASCII converter.
// No dependencies; used by the controller, datapath and top level.
package itoa_pkg;

  localparam int VALUE_W   = 32;
  localparam int RADIX_W   = 6;
  localparam int DIGIT_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int BIT_CNT_W = $clog2(VALUE_W);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] DECIMAL   = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_bad;
    logic emit_sign;
    logic rd_issue;
    logic emit_digit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic radix_bad;
    logic bit_last;
    logic quot_zero;
    logic store_full;
    logic negative;
    logic count_zero;
  } dp_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DIGIT_W'(10)) begin
      return CHAR_ZERO + dx;
    end
    return CHAR_A + dx - CHAR_W'(10);
  endfunction

endpackage

// ----- rtl/itoa_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module itoa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/itoa_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the converter: reject a bad radix, or divide digits, then emit sign and digits.
// Depends on itoa_pkg.
module itoa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  itoa_pkg::dp_status_t status,
  output itoa_pkg::ctrl_cmd_t  cmd,
  output logic                 busy
);

  import itoa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (status.radix_bad) begin
            cmd.emit_bad = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        // stop gathering once the quotient is gone or the store is full
        if (status.bit_last && (status.quot_zero || status.store_full)) begin
          state_next = status.negative ? ST_SIGN : ST_READ;
        end
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next    = ST_READ;
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_digit = 1'b1;
        state_next     = status.count_zero ? ST_IDLE : ST_READ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ----- rtl/itoa_dp.sv -----
`timescale 1ns / 1ps
// Datapath: bit-serial restoring divider, digit store and output registers.
// Depends on itoa_pkg and itoa_ram.
module itoa_dp #(
  parameter int DIGIT_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic signed [itoa_pkg::VALUE_W-1:0] value,
  input  logic [itoa_pkg::RADIX_W-1:0]    radix,
  input  itoa_pkg::ctrl_cmd_t             cmd,
  output itoa_pkg::dp_status_t            status,
  output logic                            strobe,
  output logic [itoa_pkg::CHAR_W-1:0]     char_code,
  output logic                            last,
  output logic                            bad_radix
);

  import itoa_pkg::*;

  localparam int AW = $clog2(DIGIT_DEPTH);
  localparam int CW = $clog2(DIGIT_DEPTH + 1);

  logic [VALUE_W-1:0]   remaining;
  logic [DIGIT_W-1:0]   rem;
  logic [RADIX_W-1:0]   radix_q;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [CW-1:0]        count;
  logic                 negative;

  logic [DIGIT_W:0]     partial;
  logic [DIGIT_W:0]     diff;
  logic                 q_bit;
  logic [DIGIT_W-1:0]   rem_next;
  logic [VALUE_W-1:0]   remaining_next;
  logic [CW-1:0]        count_dec;
  logic                 neg_in;
  logic                 bit_last;
  logic [DIGIT_W-1:0]   rdata;

  // shift in the next dividend bit, subtract the radix where it fits
  always_comb begin
    partial        = {rem, remaining[VALUE_W-1]};
    diff           = partial - {1'b0, radix_q};
    q_bit          = (partial >= {1'b0, radix_q});
    rem_next       = q_bit ? diff[DIGIT_W-1:0] : partial[DIGIT_W-1:0];
    remaining_next = {remaining[VALUE_W-2:0], q_bit};
  end

  assign bit_last  = (bit_cnt == BIT_CNT_W'(VALUE_W - 1));
  assign count_dec = count - CW'(1);
  assign neg_in    = (radix == DECIMAL) && value[VALUE_W-1];

  assign status.radix_bad  = (radix < RADIX_MIN) || (radix > RADIX_MAX);
  assign status.bit_last   = bit_last;
  assign status.quot_zero  = (remaining_next == '0);
  assign status.store_full = (count == CW'(DIGIT_DEPTH - 1));
  assign status.negative   = negative;
  assign status.count_zero = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      rem       <= '0;
      bit_cnt   <= '0;
      count     <= '0;
      negative  <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      strobe <= cmd.emit_bad || cmd.emit_sign || cmd.emit_digit;
      if (cmd.load) begin
        negative  <= neg_in;
        remaining <= neg_in ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
        rem       <= '0;
        bit_cnt   <= '0;
        count     <= '0;
      end else if (cmd.div_step) begin
        remaining <= remaining_next;
        bit_cnt   <= bit_cnt + BIT_CNT_W'(1);
        if (bit_last) begin
          rem   <= '0;
          count <= count + CW'(1);
        end else begin
          rem <= rem_next;
        end
      end else if (cmd.rd_issue) begin
        count <= count_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      radix_q <= radix;
    end
    if (cmd.emit_bad) begin
      char_code <= CHAR_NONE;
      last      <= 1'b1;
      bad_radix <= 1'b1;
    end else if (cmd.emit_sign) begin
      char_code <= CHAR_MINUS;
      last      <= 1'b0;
      bad_radix <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_code <= digit_char(rdata);
      last      <= (count == '0);
      bad_radix <= 1'b0;
    end
  end

  itoa_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.div_step && bit_last),
    .waddr (count[AW-1:0]),
    .wdata (rem_next),
    .raddr (count_dec[AW-1:0]),
    .rdata (rdata)
  );

endmodule

// ----- rtl/integer_to_radix_ascii.sv -----
`timescale 1ns / 1ps
// Top level of the integer-to-ASCII converter, radix 2 to 36.
// Depends on itoa_pkg, itoa_ctrl and itoa_dp.
//
// A word is taken when start is high and busy is low. Each digit is built
// in the one-bit-per-cycle divider, then every digit is read back from
// the digit store and shown, after a leading minus where there is one, and
// the next word can be taken as soon as busy drops. A bad radix gives its
// single error word in the cycle after start and leaves busy low. Each
// character appears on char_code for exactly one cycle with strobe high; the
// receiver cannot stall and must take it then.
module integer_to_radix_ascii #(
  parameter int DIGIT_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [itoa_pkg::VALUE_W-1:0] value,
  input  logic [itoa_pkg::RADIX_W-1:0]        radix,
  output logic                                busy,
  output logic                                strobe,
  output logic [itoa_pkg::CHAR_W-1:0]         char_code,
  output logic                                last,
  output logic                                bad_radix
);

  import itoa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  itoa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  itoa_dp #(
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .radix     (radix),
    .cmd       (cmd),
    .status    (status),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last),
    .bad_radix (bad_radix)
  );

endmodule

// ----- rtl/itoa_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the integer-to-ASCII converter, bound to the top.
// Depends on itoa_pkg.
module itoa_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                strobe,
  input logic [itoa_pkg::CHAR_W-1:0]         char_code,
  input logic                                last,
  input logic                                bad_radix
);

  import itoa_pkg::*;

  // error word is a lone terminating word with no character
  a_bad_form: assert property (@(posedge clk) disable iff (rst)
    strobe && bad_radix |-> last && (char_code == CHAR_NONE))
    else $error("bad radix word malformed");

  // error word answers a start taken on the previous cycle
  a_bad_timing: assert property (@(posedge clk) disable iff (rst)
    strobe && bad_radix |-> $past(start && !busy))
    else $error("bad radix word without a start");

  // busy only rises off an accepted start
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // mid-string words arrive while the conversion still holds busy
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !bad_radix && !last |-> busy)
    else $error("non-final character after conversion ended");

  // a minus sign never ends a string
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (char_code == CHAR_MINUS) |-> !last)
    else $error("minus sign marked last");

endmodule

bind integer_to_radix_ascii itoa_checker u_itoa_checker (.*);
